### rtl/c8ie_pkg.sv
// c8ie_pkg: shared types, codes and helpers for the chip-8 execute block
// no dependencies

package c8ie_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [11:0] START_ADDR_RST = 12'h200;

    typedef enum logic [2:0] {
        K_STATUS = 3'd0, K_MEMWR = 3'd1, K_MEMRD = 3'd2, K_CLEAR = 3'd3,
        K_DRAW = 3'd4, K_DELAY = 3'd5, K_SOUND = 3'd6, K_WAITKEY = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE = 3'd0, E_EMPTY = 3'd1, E_FULL = 3'd2, E_ADDR = 3'd3, E_OPC = 3'd4
    } t_err;

    typedef struct packed {
        logic        func;
        logic [15:0] instr;
        logic [15:0] key_pressed_map;
        logic [7:0]  random_byte;
        logic [7:0]  delay_value;
        logic [3:0]  wb_reg;
        logic [7:0]  wb_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  request_kind;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [3:0]  target_reg;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic [7:0]  timer_value;
        logic [11:0] next_pc;
        logic [2:0]  error_code;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_EMIT, S_BLOCK, S_STATUS, S_WAIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic exec;     // decode and commit
        logic emit;     // put request into output register
        logic step;     // next block-transfer element
        logic status;   // put status into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_wb;
        logic has_req;
        logic is_block;
        logic block_done;
        logic out_full;
    } t_stat;

    // bcd digits of a byte via small reciprocal multiplies
    function automatic logic [11:0] bcd8(input logic [7:0] v);
        logic [15:0] q100, q10;
        logic [3:0]  h, t, o;
        logic [7:0]  rem;
        q100 = 16'(v) * 16'd41;        // /100 for v<256
        h    = 4'(q100 >> 12);
        rem  = v - (8'(h) * 8'd100);
        q10  = 16'(rem) * 16'd205;     // /10 for rem<100
        t    = 4'(q10 >> 11);
        o    = 4'(rem - (8'(t) * 8'd10));
        return {h, t, o};
    endfunction

endpackage

### rtl/c8ie_ctrl.sv
// c8ie_ctrl: sequencing state machine for the chip-8 execute block
// depends on c8ie_pkg

module c8ie_ctrl import c8ie_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;
    logic   can_put;

    assign can_put = !i_stat.out_full || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_wb) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.is_block) begin
                    n_state = S_BLOCK;
                end else if (i_stat.has_req) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_STATUS;
                end
            end
            S_EMIT: begin
                if (can_put) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_STATUS;
                end
            end
            S_BLOCK: begin
                if (can_put) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.step = 1'b1;
                    if (i_stat.block_done) n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                if (can_put) begin
                    o_cmd.exec   = 1'b1;
                    o_cmd.status = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // an item is taken only when idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    // status only when output can take it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.status |-> can_put)
        else $error("status overruns output");
    // no emit and status together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit && o_cmd.status))
        else $error("emit and status in one cycle");
endmodule

### rtl/c8ie_dp.sv
// c8ie_dp: registers, return stack, decode and output register
// depends on c8ie_pkg

module c8ie_dp import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic        o_valid,
    input  logic        i_out_ready,
    output t_out_item   o_item
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    t_in_item    r_in;
    logic [7:0]  r_v [16];
    logic [11:0] r_i, r_pc, r_sa;
    logic [SPW-1:0] r_sp;
    logic [11:0] r_stk [STACK_DEPTH];
    logic [11:0] r_top;
    logic [3:0]  r_k;
    t_out_item   r_out;
    logic        r_ov;

    logic [3:0]  x, y, n;
    logic [7:0]  kk, vx, vy;
    logic [11:0] nnn, pc2, pc4, npc;
    logic [12:0] bsum;
    t_err        err;
    t_out_item   req;
    t_out_item   st;
    logic        has_req, is_block, push, pop, full, empty;
    logic        wr_x, wr_f;
    logic [7:0]  val_x, val_f;
    logic [11:0] n_i;
    logic        wr_i;
    logic [11:0] bcd;
    logic [8:0]  sum9;
    logic        down;

    assign x = r_in.instr[11:8];
    assign y = r_in.instr[7:4];
    assign n = r_in.instr[3:0];
    assign kk = r_in.instr[7:0];
    assign nnn = r_in.instr[11:0];
    assign vx = r_v[x];
    assign vy = r_v[y];
    assign pc2 = r_pc + 12'd2;
    assign pc4 = r_pc + 12'd4;
    assign full = r_sp >= SPW'(STACK_DEPTH);
    assign empty = r_sp == '0;
    assign bsum = {1'b0, nnn} + {5'd0, r_v[0]};
    assign bcd = bcd8(vx);
    assign sum9 = {1'b0, vx} + {1'b0, vy};
    assign down = (vx[7:4] == 4'd0) && r_in.key_pressed_map[vx[3:0]];

    always_comb begin
        err = E_NONE; npc = pc2; req = '0; has_req = 1'b0; is_block = 1'b0;
        push = 1'b0; pop = 1'b0; wr_x = 1'b0; wr_f = 1'b0; val_x = '0; val_f = '0;
        wr_i = 1'b0; n_i = r_i;
        unique case (r_in.instr[15:12])
            4'h0: begin
                if (r_in.instr == 16'h00E0) begin
                    has_req = 1'b1; req.request_kind = K_CLEAR;
                end else if (r_in.instr == 16'h00EE) begin
                    if (empty) err = E_EMPTY;
                    else begin pop = 1'b1; npc = r_top; end
                end else if (full) err = E_FULL;
                else begin push = 1'b1; npc = nnn; end
            end
            4'h1: npc = nnn;
            4'h2: begin
                if (full) err = E_FULL;
                else begin push = 1'b1; npc = nnn; end
            end
            4'h3: if (vx == kk) npc = pc4;
            4'h4: if (vx != kk) npc = pc4;
            4'h5: begin
                if (n != 4'd0) err = E_OPC;
                else if (vx == vy) npc = pc4;
            end
            4'h6: begin wr_x = 1'b1; val_x = kk; end
            4'h7: begin wr_x = 1'b1; val_x = vx + kk; end
            4'h8: begin
                case (n)
                    4'h0: begin wr_x = 1'b1; val_x = vy; end
                    4'h1: begin wr_x = 1'b1; val_x = vx | vy; end
                    4'h2: begin wr_x = 1'b1; val_x = vx & vy; end
                    4'h3: begin wr_x = 1'b1; val_x = vx ^ vy; end
                    4'h4: begin
                        wr_x = 1'b1; val_x = sum9[7:0]; wr_f = 1'b1; val_f = {7'd0, sum9[8]};
                    end
                    4'h5: begin
                        wr_x = 1'b1; val_x = vx - vy; wr_f = 1'b1; val_f = {7'd0, vx >= vy};
                    end
                    4'h6: begin
                        wr_x = 1'b1; val_x = {1'b0, vx[7:1]}; wr_f = 1'b1; val_f = {7'd0, vx[0]};
                    end
                    4'h7: begin
                        wr_x = 1'b1; val_x = vy - vx; wr_f = 1'b1; val_f = {7'd0, vy >= vx};
                    end
                    4'hE: begin
                        wr_x = 1'b1; val_x = {vx[6:0], 1'b0}; wr_f = 1'b1; val_f = {7'd0, vx[7]};
                    end
                    default: err = E_OPC;
                endcase
            end
            4'h9: begin
                if (n != 4'd0) err = E_OPC;
                else if (vx != vy) npc = pc4;
            end
            4'hA: begin wr_i = 1'b1; n_i = nnn; end
            4'hB: begin
                if (bsum[12]) err = E_ADDR;
                else npc = bsum[11:0];
            end
            4'hC: begin wr_x = 1'b1; val_x = r_in.random_byte & kk; end
            4'hD: begin
                has_req = 1'b1; req.request_kind = K_DRAW; req.mem_addr = r_i;
                req.target_reg = 4'd15; req.draw_x = vx; req.draw_y = vy; req.draw_rows = n;
            end
            4'hE: begin
                if (kk == 8'h9E) begin
                    if (down) npc = pc4;
                end else if (kk == 8'hA1) begin
                    if (!down) npc = pc4;
                end else err = E_OPC;
            end
            default: begin
                case (kk)
                    8'h07: begin wr_x = 1'b1; val_x = r_in.delay_value; end
                    8'h0A: begin
                        has_req = 1'b1; req.request_kind = K_WAITKEY; req.target_reg = x;
                    end
                    8'h15: begin
                        has_req = 1'b1; req.request_kind = K_DELAY; req.timer_value = vx;
                    end
                    8'h18: begin
                        has_req = 1'b1; req.request_kind = K_SOUND; req.timer_value = vx;
                    end
                    8'h1E: begin wr_i = 1'b1; n_i = r_i + {4'd0, vx}; end
                    8'h29: begin wr_i = 1'b1; n_i = {2'd0, vx, 2'd0} + {4'd0, vx}; end
                    8'h33, 8'h55, 8'h65: is_block = 1'b1;
                    default: err = E_OPC;
                endcase
            end
        endcase
        // block transfer element k
        if (is_block) begin
            req.mem_addr = r_i + {8'd0, r_k};
            if (kk == 8'h65) begin
                req.request_kind = K_MEMRD; req.target_reg = r_k;
            end else begin
                req.request_kind = K_MEMWR;
                if (kk == 8'h33) req.mem_data = (r_k == 4'd0) ? {4'd0, bcd[11:8]} :
                                                (r_k == 4'd1) ? {4'd0, bcd[7:4]} :
                                                                {4'd0, bcd[3:0]};
                else req.mem_data = r_v[r_k];
            end
        end
        if (err != E_NONE) npc = r_pc;
    end

    // status item closing an instruction
    always_comb begin
        st = '0;
        st.request_kind = K_STATUS;
        st.next_pc = npc;
        st.error_code = err;
        st.last = 1'b1;
    end

    assign o_stat.is_wb = r_in.func;
    assign o_stat.has_req = has_req;
    assign o_stat.is_block = is_block;
    assign o_stat.block_done = (kk == 8'h33) ? (r_k == 4'd2) : (r_k == x);
    assign o_stat.out_full = r_ov;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        if (i_cmd.load) r_k <= '0;
        else if (i_cmd.step) r_k <= r_k + 4'd1;
        // return stack top kept one read ahead of a pop
        r_top <= (r_sp == '0) ? '0 : r_stk[SAW'(r_sp - SPW'(1))];
        if (i_cmd.exec && !r_in.func && push) r_stk[SAW'(r_sp)] <= pc2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 16; j++) r_v[j] <= '0;
            r_i <= '0; r_sa <= START_ADDR_RST; r_pc <= START_ADDR_RST; r_sp <= '0;
        end else if (i_cfg_we) begin
            r_sa <= i_cfg_data; r_pc <= i_cfg_data;
        end else if (i_cmd.exec) begin
            if (r_in.func) r_v[r_in.wb_reg] <= r_in.wb_value;
            else begin
                if (err == E_NONE) begin
                    // vf flag wins when x is vf
                    if (wr_x && !(wr_f && x == 4'd15)) r_v[x] <= val_x;
                    if (wr_f) r_v[15] <= val_f;
                    if (wr_i) r_i <= n_i;
                    if (push) r_sp <= r_sp + SPW'(1);
                    if (pop)  r_sp <= r_sp - SPW'(1);
                end
                r_pc <= npc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.emit || i_cmd.status) r_ov <= 1'b1;
        else if (i_out_ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= req;
        else if (i_cmd.status) r_out <= st;
    end

    assign o_valid = r_ov;
    assign o_item = r_out;

    // stack pointer never passes its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer overflow");
    // an error never moves the pc
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !r_in.func && err != E_NONE && !i_cfg_we) |=> $stable(r_pc))
        else $error("pc moved on error");
    // output register is loaded only when free or drained
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.status) |-> (!r_ov || i_out_ready))
        else $error("output overwrite");
    // sa tracked for completeness
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_sa == $past(i_cfg_data))
        else $error("start address not taken");
endmodule

### rtl/chip8_instruction_execute_top.sv
// chip8_instruction_execute_top: top level of the chip-8 execute block
// depends on c8ie_pkg, c8ie_ctrl, c8ie_dp

// One input item is taken at a time. An execute item runs one instruction and
// emits its requests then a status item (last=1) with next pc and error code;
// a write-back item (func=1) writes one register and emits nothing. The
// sequencer puts one item per cycle into the single output register while the
// output side can take it, and an output stall holds it. Configuration writes
// reload the program counter; they are allowed while idle only, a rule on the
// user that the block itself does not enforce.
module chip8_instruction_execute_top import c8ie_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item
);
    t_cmd  cmd;
    t_stat stat;

    // sequencer
    c8ie_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .i_stat(stat), .o_cmd(cmd)
    );

    // registers, stack, decode, output register
    c8ie_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_item(i_item), .i_cmd(cmd), .o_stat(stat), .o_valid(o_valid),
        .i_out_ready(i_ready), .o_item(o_item)
    );
endmodule
